>>> rtl/upip_pkg.sv
// Shared types and constants of the URI path id parser.
// No dependencies; the interfaces and rtl modules reference it by scoped names.
package upip_pkg;

  localparam int unsigned ID_W       = 16;
  localparam int unsigned NUM_LEVELS = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_FOURTH = 1'd1;

  localparam logic [ID_W-1:0] ID_LIMIT_RST = 16'hFFFF;
  localparam logic [ID_W-1:0] ID_MAX       = 16'hFFFF;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
    logic       no_character;
  } upip_in_t;

  typedef struct packed {
    logic            accepted;
    logic [ID_W-1:0] consumed;
    logic [ID_W-1:0] object_id;
    logic            object_valid;
    logic [ID_W-1:0] instance_id;
    logic            instance_valid;
    logic [ID_W-1:0] resource_id;
    logic            resource_valid;
    logic [ID_W-1:0] res_instance_id;
    logic            res_instance_valid;
  } upip_out_t;

endpackage

>>> rtl/upip_in_if.sv
// Valid/ready channel carrying one path byte per beat.
// Depends on upip_pkg for the payload type.
interface upip_in_if;
  logic               valid;
  logic               ready;
  upip_pkg::upip_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/upip_out_if.sv
// Valid/ready channel carrying one parse result per beat.
// Depends on upip_pkg for the payload type.
interface upip_out_if;
  logic                valid;
  logic                ready;
  upip_pkg::upip_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/uri_path_id_parser.sv
// Top level of the URI path id parser: input register, parse logic, result register.
// Depends on upip_pkg, upip_in_if and upip_out_if.
//
// Usage:
//   in_if  carries one byte of a path string per beat, with last marking the
//          final beat and no_character marking a beat without a byte (used to
//          close an empty string). Beats that are not last produce nothing.
//   out_if delivers exactly one result beat per string, on its last beat:
//          accept flag, consumed length (0 on reject) and four ids with
//          their valid flags.
//   cfg_*  writes id_limit (index 0) and allow_fourth_level (index 1); write
//          only while no string is in flight.
// Throughput: one beat per cycle; only a last beat waits while the result is held.
//   The result of a last beat is registered and then shows on out_if.
//   The per-byte work is one compare plus a multiply-by-ten add on the
//   16-bit accumulator, between the input register and the state/result regs.
// Reset (rst_n low, synchronous): drop any in-flight beat and result, clear
//   parse state, id_limit returns to 65535, allow_fourth_level to 1.
// Stall: a held result does not block byte beats; only a last beat waits in
//   the input register until the result register is free, and then in_if
//   backs up.
module uri_path_id_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  upip_in_if.sink                            in_if,
  upip_out_if.source                         out_if,
  input  logic                               cfg_we,
  input  logic [upip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [upip_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // parse phase codes
  localparam logic [1:0] PH_SPACE     = 2'd0;
  localparam logic [1:0] PH_SEG_START = 2'd1;
  localparam logic [1:0] PH_DIGITS    = 2'd2;

  localparam int unsigned W = upip_pkg::ID_W;

  // configuration
  logic [W-1:0] id_limit_r;
  logic         allow4_r;

  // input register
  logic               s1_valid_r;
  upip_pkg::upip_in_t s1_data_r;

  // parse state
  logic [1:0]   phase_r,  phase_nxt;
  logic [1:0]   level_r,  level_nxt;
  logic [W-1:0] acc_r,    acc_nxt;
  logic [W-1:0] count_r,  count_nxt;
  logic         failed_r, failed_nxt;
  logic [W-1:0] ids_r   [upip_pkg::NUM_LEVELS];
  logic [W-1:0] ids_nxt [upip_pkg::NUM_LEVELS];
  logic [upip_pkg::NUM_LEVELS-1:0] vbits_r, vbits_nxt;

  // result register
  logic                out_valid_r;
  upip_pkg::upip_out_t out_data_r, out_data_nxt;

  logic out_free, s1_go;
  logic [7:0] c;
  logic is_white, is_digit;
  logic [W+3:0] acc_mul;
  logic ok;

  // handshake: a byte beat always advances, a last beat needs the result slot
  assign out_free    = !out_valid_r || out_if.ready;
  assign s1_go       = s1_valid_r && (!s1_data_r.last || out_free);
  assign in_if.ready = !s1_valid_r || s1_go;

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_data_r;

  assign c        = s1_data_r.char_byte;
  assign is_white = (c == upip_pkg::CHAR_SPACE) ||
                    (c >= upip_pkg::CHAR_TAB && c <= upip_pkg::CHAR_CR);
  assign is_digit = (c >= upip_pkg::CHAR_ZERO) && (c <= upip_pkg::CHAR_NINE);
  // acc * 10 + digit; the digit value is the low nibble of an ASCII digit
  assign acc_mul  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'd0, c[3:0]};

  always_comb begin
    phase_nxt  = phase_r;
    level_nxt  = level_r;
    acc_nxt    = acc_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    vbits_nxt  = vbits_r;
    for (int i = 0; i < upip_pkg::NUM_LEVELS; i++) begin
      ids_nxt[i] = ids_r[i];
    end
    ok = 1'b0;

    if (!s1_data_r.no_character) begin
      if (count_r != upip_pkg::ID_MAX) begin
        count_nxt = count_r + 16'd1;
      end
      if (!failed_r) begin
        unique case (phase_r)
          PH_SPACE: begin
            if (!is_white) begin
              if (c == upip_pkg::CHAR_SLASH) begin
                phase_nxt = PH_SEG_START;
                level_nxt = 2'd0;
              end else begin
                failed_nxt = 1'b1;
              end
            end
          end
          PH_SEG_START: begin
            if ((level_r == 2'd3 && !allow4_r) || !is_digit) begin
              failed_nxt = 1'b1;
            end else begin
              acc_nxt   = {12'd0, c[3:0]};
              phase_nxt = PH_DIGITS;
            end
          end
          default: begin
            if (is_digit) begin
              acc_nxt = (acc_mul > {4'd0, upip_pkg::ID_MAX}) ? upip_pkg::ID_MAX
                                                             : acc_mul[W-1:0];
            end else if (c == upip_pkg::CHAR_SLASH) begin
              // close the segment, then open the next level; a slash after the last allowed level fails
              if (acc_r >= id_limit_r) begin
                failed_nxt = 1'b1;
              end else begin
                ids_nxt[level_r]   = acc_r;
                vbits_nxt[level_r] = 1'b1;
                if (level_r == 2'd3 || (level_r == 2'd2 && !allow4_r)) begin
                  failed_nxt = 1'b1;
                end else begin
                  level_nxt = level_r + 2'd1;
                  phase_nxt = PH_SEG_START;
                end
              end
            end else begin
              failed_nxt = 1'b1;
            end
          end
        endcase
      end
    end

    // end of string: close a pending segment and decide acceptance
    if (s1_data_r.last && !failed_nxt) begin
      if (phase_nxt == PH_SEG_START) begin
        ok = !(level_nxt == 2'd3 && !allow4_r);
      end else if (phase_nxt == PH_DIGITS && acc_nxt < id_limit_r) begin
        ids_nxt[level_nxt]   = acc_nxt;
        vbits_nxt[level_nxt] = 1'b1;
        ok = 1'b1;
      end
    end

    out_data_nxt.accepted           = ok;
    out_data_nxt.consumed           = ok ? count_nxt : '0;
    out_data_nxt.object_id          = vbits_nxt[0] ? ids_nxt[0] : '0;
    out_data_nxt.object_valid       = vbits_nxt[0];
    out_data_nxt.instance_id        = vbits_nxt[1] ? ids_nxt[1] : '0;
    out_data_nxt.instance_valid     = vbits_nxt[1];
    out_data_nxt.resource_id        = vbits_nxt[2] ? ids_nxt[2] : '0;
    out_data_nxt.resource_valid     = vbits_nxt[2];
    out_data_nxt.res_instance_id    = vbits_nxt[3] ? ids_nxt[3] : '0;
    out_data_nxt.res_instance_valid = vbits_nxt[3];

    // a finished string leaves a clean state for the next one
    if (s1_data_r.last) begin
      phase_nxt  = PH_SPACE;
      level_nxt  = 2'd0;
      acc_nxt    = '0;
      count_nxt  = '0;
      failed_nxt = 1'b0;
      vbits_nxt  = '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_limit_r <= upip_pkg::ID_LIMIT_RST;
      allow4_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        upip_pkg::CFG_ID_LIMIT:     id_limit_r <= cfg_wdata;
        upip_pkg::CFG_ALLOW_FOURTH: allow4_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_data_r <= in_if.payload;
    end
  end

  // parse state: advance once per beat leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SPACE;
      level_r  <= 2'd0;
      acc_r    <= '0;
      count_r  <= '0;
      failed_r <= 1'b0;
      vbits_r  <= '0;
    end else if (s1_go) begin
      phase_r  <= phase_nxt;
      level_r  <= level_nxt;
      acc_r    <= acc_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
      vbits_r  <= vbits_nxt;
    end
  end

  // id store is masked by the valid bits, so it holds without reset
  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int i = 0; i < upip_pkg::NUM_LEVELS; i++) begin
        ids_r[i] <= ids_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_data_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_data_r.last) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> rtl/upip_checker.sv
// Port-level checks for uri_path_id_parser, attached by the bind at the end.
// Depends on upip_pkg for the result type.
module upip_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input upip_pkg::upip_out_t out_payload
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a reject reports no consumed length
  a_reject_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.accepted |-> out_payload.consumed == '0)
    else $error("nonzero consumed length on reject");

  // ids are filled in level order and read zero when not valid
  a_id_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (!out_payload.instance_valid || out_payload.object_valid) &&
      (!out_payload.resource_valid || out_payload.instance_valid) &&
      (!out_payload.res_instance_valid || out_payload.resource_valid) &&
      (out_payload.object_valid || out_payload.object_id == '0) &&
      (out_payload.instance_valid || out_payload.instance_id == '0) &&
      (out_payload.resource_valid || out_payload.resource_id == '0) &&
      (out_payload.res_instance_valid || out_payload.res_instance_id == '0))
    else $error("id valid flags out of order or stale id");

endmodule

bind uri_path_id_parser upip_checker u_upip_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_payload (out_if.payload)
);
